### rtl/smt_pkg.sv
// Package for the small-state twister: item kind codes, generator constants,
// control state type and the output tempering function.
// No dependencies.
`default_nettype none

package smt_pkg;

	localparam logic [1:0] KIND_SEED = 2'd0;
	localparam logic [1:0] KIND_XOR  = 2'd1;
	localparam logic [1:0] KIND_GEN  = 2'd2;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] SEED_MULT    = 32'd1712438297;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B     = 32'h9c4f_88e3;
	localparam logic [31:0] TEMPER_C     = 32'he7f7_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_TW_PRIME,
		ST_TW_RD,
		ST_TW_WR,
		ST_XOR_WR,
		ST_GEN_RD,
		ST_GEN_OUT
	} smt_state_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

### rtl/smt_cmd_if.sv
// Command channel: valid/ready handshake carrying one input item.
// No dependencies.
`default_nettype none

interface smt_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [5:0]  word_index;
	logic [31:0] value;

	modport source (output valid, output kind, output word_index, output value, input ready);
	modport sink   (input valid, input kind, input word_index, input value, output ready);
endinterface

`default_nettype wire

### rtl/smt_rsp_if.sv
// Result channel: valid/ready handshake carrying one tempered word.
// No dependencies.
`default_nettype none

interface smt_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

### rtl/small_state_mersenne_twister.sv
// Top level of the small-state twister generator: sequencer, seed and twist
// datapath around the state RAM. Uses smt_pkg, smt_cmd_if, smt_rsp_if, smt_ram.
//
//   channel  dir  handshake         payload
//   cmd      in   valid/ready       kind[1:0], word_index[5:0], value[31:0]
//   rsp      out  valid/ready       random_value[31:0]
//
// Sequencing: one item at a time; cmd.ready is high only when the sequencer
// is idle. A seed item takes one multiply and one add/write per word. A key
// item reads the word, then writes it back. A generate item reads and returns
// a word when state words are left, twists the state first when it is used
// up (per word a dual read, then a write), and runs a full seed pass before
// that when the generator was never seeded. The seed product and the RAM
// reads are registered, and the steps do not overlap.
// Reset clears the sequencer and marks the generator unseeded; the RAM needs
// no clearing because every generated word comes after a full seed pass.
// A result waiting on rsp does not block cmd; only the next result stalls.
`default_nettype none

module small_state_mersenne_twister #(
	parameter int STATE_WORDS  = 64,
	parameter int TWIST_OFFSET = 39
) (
	input wire logic clk,
	input wire logic arst_n,
	smt_cmd_if.sink   cmd,
	smt_rsp_if.source rsp
);

	localparam int AW      = $clog2(STATE_WORDS);
	localparam int PW      = $clog2(STATE_WORDS + 2);
	localparam int OFF_MOD = TWIST_OFFSET % STATE_WORDS;

	// position codes: N means used up, N+1 means never seeded
	localparam logic [PW-1:0] POS_EMPTY    = PW'(STATE_WORDS);
	localparam logic [PW-1:0] POS_UNSEEDED = PW'(STATE_WORDS + 1);
	localparam logic [AW-1:0] LAST_WORD    = AW'(STATE_WORDS - 1);

	smt_pkg::smt_state_t state_q, state_d;

	logic [PW-1:0] pos_q;          // next read position
	logic          twist_pend_q;   // seed pass started by a generate item
	logic [AW-1:0] k_q;            // word being seeded / twisted
	logic [AW-1:0] j_q;            // (k + offset) mod N
	logic [31:0]   p_q;            // previous seed word
	logic [31:0]   prod_q;         // registered seed product
	logic          cur_hi_q;       // old word k, bit 31
	logic          cur_lo_q;       // old word k, bit 0
	logic [31:0]   val_q;
	logic [AW-1:0] idx_q;
	logic          rsp_valid_q;
	logic [31:0]   rsp_data_q;

	// RAM ports
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW-1:0] raddr_a;
	logic [31:0]   rdata_a;
	logic [31:0]   rdata_b;

	logic          accept;
	logic          rsp_free;
	logic          key_in_range;
	logic [AW-1:0] k_next;
	logic          tw_last;
	logic [31:0]   seed_word;
	logic [31:0]   twist_word;
	logic [31:0]   twist_y;
	logic          twist_mbit;

	assign cmd.ready        = (state_q == smt_pkg::ST_IDLE);
	assign accept           = cmd.valid && cmd.ready;
	assign rsp_free         = !rsp_valid_q || rsp.ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.random_value = rsp_data_q;
	assign key_in_range     = 32'(cmd.word_index) < 32'(STATE_WORDS);

	assign k_next  = (k_q == LAST_WORD) ? '0 : AW'(k_q + 1'b1);
	assign tw_last = (k_q == LAST_WORD);

	// seed recurrence: w[k] = M * (p ^ (p >> 30)) + k, product registered first
	assign seed_word = prod_q + 32'(k_q);

	// twist: rdata_a = word k+1 (old) or word 0 (new) on the last step,
	// rdata_b = word (k + offset) mod N as currently stored.
	// Lower 31 bits of the neighbor are shifted; the last word takes the
	// matrix term from its own old low bit.
	assign twist_y    = {cur_hi_q, 1'b0, rdata_a[30:1]};
	assign twist_mbit = tw_last ? cur_lo_q : rdata_a[0];
	assign twist_word = rdata_b ^ twist_y ^ (twist_mbit ? smt_pkg::TWIST_MATRIX : 32'h0);

	smt_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (j_q),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = k_q;
		wdata   = seed_word;
		raddr_a = AW'(pos_q);
		unique case (state_q)
			smt_pkg::ST_IDLE: begin
				raddr_a = AW'(cmd.word_index);
				if (accept) begin
					case (cmd.kind)
						smt_pkg::KIND_SEED: begin
							we      = 1'b1;
							waddr   = '0;
							wdata   = cmd.value;
							state_d = smt_pkg::ST_SEED_MUL;
						end
						smt_pkg::KIND_XOR: begin
							if (key_in_range) begin
								state_d = smt_pkg::ST_XOR_WR;
							end
						end
						smt_pkg::KIND_GEN: begin
							if (pos_q == POS_UNSEEDED) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = smt_pkg::DEFAULT_SEED;
								state_d = smt_pkg::ST_SEED_MUL;
							end else if (pos_q == POS_EMPTY) begin
								state_d = smt_pkg::ST_TW_PRIME;
							end else begin
								state_d = smt_pkg::ST_GEN_RD;
							end
						end
						default: begin
							state_d = smt_pkg::ST_IDLE;
						end
					endcase
				end
			end
			smt_pkg::ST_SEED_MUL: begin
				state_d = smt_pkg::ST_SEED_ADD;
			end
			smt_pkg::ST_SEED_ADD: begin
				we    = 1'b1;
				waddr = k_q;
				wdata = seed_word;
				if (k_q == LAST_WORD) begin
					state_d = twist_pend_q ? smt_pkg::ST_TW_PRIME : smt_pkg::ST_IDLE;
				end else begin
					state_d = smt_pkg::ST_SEED_MUL;
				end
			end
			smt_pkg::ST_TW_PRIME: begin
				raddr_a = '0;
				state_d = smt_pkg::ST_TW_RD;
			end
			smt_pkg::ST_TW_RD: begin
				raddr_a = k_next;
				state_d = smt_pkg::ST_TW_WR;
			end
			smt_pkg::ST_TW_WR: begin
				raddr_a = k_next;
				we      = 1'b1;
				waddr   = k_q;
				wdata   = twist_word;
				state_d = tw_last ? smt_pkg::ST_GEN_RD : smt_pkg::ST_TW_RD;
			end
			smt_pkg::ST_XOR_WR: begin
				we      = 1'b1;
				waddr   = idx_q;
				wdata   = rdata_a ^ val_q;
				state_d = smt_pkg::ST_IDLE;
			end
			smt_pkg::ST_GEN_RD: begin
				state_d = smt_pkg::ST_GEN_OUT;
			end
			smt_pkg::ST_GEN_OUT: begin
				// address held on pos_q so the read data survives a stall
				if (rsp_free) begin
					state_d = smt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smt_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_UNSEEDED;
			twist_pend_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				twist_pend_q <= (cmd.kind == smt_pkg::KIND_GEN);
			end
			if (state_q == smt_pkg::ST_SEED_ADD && k_q == LAST_WORD) begin
				pos_q <= POS_EMPTY;
			end else if (state_q == smt_pkg::ST_TW_WR && tw_last) begin
				pos_q <= '0;
			end else if (state_q == smt_pkg::ST_GEN_OUT && rsp_free) begin
				pos_q <= PW'(pos_q + 1'b1);
			end
			if (state_q == smt_pkg::ST_GEN_OUT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			smt_pkg::ST_IDLE: begin
				val_q <= cmd.value;
				idx_q <= AW'(cmd.word_index);
				k_q   <= AW'(1);
				p_q   <= (cmd.kind == smt_pkg::KIND_SEED) ? cmd.value : smt_pkg::DEFAULT_SEED;
			end
			smt_pkg::ST_SEED_MUL: begin
				prod_q <= 32'(smt_pkg::SEED_MULT * (p_q ^ (p_q >> 30)));
			end
			smt_pkg::ST_SEED_ADD: begin
				p_q <= seed_word;
				k_q <= AW'(k_q + 1'b1);
			end
			smt_pkg::ST_TW_PRIME: begin
				k_q <= '0;
				j_q <= AW'(OFF_MOD);
			end
			smt_pkg::ST_TW_RD: begin
				if (k_q == '0) begin
					cur_hi_q <= rdata_a[31];
					cur_lo_q <= rdata_a[0];
				end
			end
			smt_pkg::ST_TW_WR: begin
				cur_hi_q <= rdata_a[31];
				cur_lo_q <= rdata_a[0];
				k_q      <= k_next;
				j_q      <= (j_q == LAST_WORD) ? '0 : AW'(j_q + 1'b1);
			end
			smt_pkg::ST_GEN_OUT: begin
				if (rsp_free) begin
					rsp_data_q <= smt_pkg::temper(rdata_a);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/smt_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
`default_nettype none

module smt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	output      logic [WIDTH-1:0] rdata_a,
	input  wire logic [AW-1:0]    raddr_b,
	output      logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

### rtl/smt_checker.sv
// Port-level checks for the small-state twister, bound to its top level.
// Depends on small_state_mersenne_twister and smt_pkg.
`default_nettype none

module smt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic [1:0]  cmd_kind,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_random_value
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	// a waiting result holds its word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
		else $error("result changed while stalled");

	// the command port is not ready right after a seed or generate item is accepted
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (cmd_kind == smt_pkg::KIND_SEED || cmd_kind == smt_pkg::KIND_GEN)
		|=> !cmd_ready)
		else $error("command port ready right after a seed or generate item");

	// a seed item never produces a result
	a_seed_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd_kind == smt_pkg::KIND_SEED |=> !$rose(rsp_valid))
		else $error("result after a seed item");

	// a new result is only raised from the busy sequencer
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("result raised while idle");

endmodule

bind small_state_mersenne_twister smt_checker u_smt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_kind         (cmd.kind),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_random_value (rsp.random_value)
);

`default_nettype wire
